FILE: hw/rtl/sst_pkg.sv
// ----------------------------------------------------------------------------
// sst_pkg: shared types for the sorted set table
// Item formats, action and status codes, and the command and status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package sst_pkg;

  // action carried by an input item
  typedef enum logic [1:0] {
    ACT_SEARCH = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_DELETE = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_t;

  // outcome reported with each result
  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_DUP  = 2'd2,
    ST_MISS = 2'd3
  } status_t;

  // input item
  typedef struct packed {
    action_t            action;
    logic signed [31:0] value;
  } in_item_t;

  // result item
  typedef struct packed {
    status_t    status;
    logic [4:0] position;
    logic [4:0] fill_count;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic    take;          // capture the input item, rewind the scan index
    logic    idx_inc;       // advance the scan index
    logic    ptr_from_cnt;  // move pointer to the fill count
    logic    ptr_from_idx;  // move pointer to the scan index
    logic    ptr_dec;
    logic    ptr_inc;
    logic    rd_idx;        // read entry at scan index
    logic    rd_lo;         // read entry below pointer
    logic    rd_hi;         // read entry above pointer
    logic    wr_shift;      // write read data at pointer
    logic    wr_value;      // write captured value at scan index
    logic    cnt_inc;
    logic    cnt_dec;
    logic    cnt_clr;
    logic    out_load;      // load the result register
    status_t out_status;
    logic    pos_zero;      // report position zero instead of the scan index
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    action_t action;
    logic    scan_end;    // scan index has reached the fill count
    logic    less;        // entry read is below the captured value
    logic    equal;       // entry read equals the captured value
    logic    full;
    logic    ptr_at_idx;  // upward shift has reached the insertion slot
    logic    ptr_at_top;  // downward shift has reached the last entry
    logic    out_busy;    // result register holds an untaken result
  } dp_status_t;

endpackage

FILE: hw/rtl/sorted_set_table.sv
// ----------------------------------------------------------------------------
// sorted_set_table: ascending duplicate-free table of signed 32-bit values
// Search, insert, delete and clear on a sorted table held in a single-port
// style memory, one item at a time.
// ----------------------------------------------------------------------------
//   channel  handshake            payload
//   in       in_valid / in_stall  in_item  (action, value)
//   out      out_valid/out_stall  out_item (status, position, fill_count)
//
// An item reads the entries one at a time in the scan; an insert or a delete
// then moves the entries above its slot one at a time, a read and a write each.
// The entry memory, one access a cycle with registered read data, sets this
// pace. A result that waits on out_stall holds up the load of the next result.
// Synchronous active-low reset empties the table; no clearing pass is needed.
// in_stall is high from acceptance until the result is loaded; the result
// register lets the next item be accepted while out_stall holds a result.
// ----------------------------------------------------------------------------
module sorted_set_table #(
  parameter int CAPACITY = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  sst_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output sst_pkg::out_item_t out_item
);

  sst_pkg::dp_cmd_t    cmd;
  sst_pkg::dp_status_t st;
  logic                idle;

  // sequencer
  sst_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .st       (st),
    .cmd      (cmd),
    .idle     (idle)
  );

  // table datapath
  sst_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .st        (st),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  assign in_stall = ~idle;

endmodule

FILE: hw/rtl/sst_ctrl.sv
// ----------------------------------------------------------------------------
// sst_ctrl: sequencer for the sorted set table
// Walks each action through scan, shift and result phases and drives the
// datapath one memory access at a time.
// ----------------------------------------------------------------------------
module sst_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  sst_pkg::dp_status_t st,
  output sst_pkg::dp_cmd_t    cmd,
  output logic                idle
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN_CHK,
    S_SCAN_CMP,
    S_INS_START,
    S_INS_CHK,
    S_INS_WR,
    S_DEL_CHK,
    S_DEL_WR,
    S_FINISH
  } state_t;

  state_t           state_r, state_nxt;
  sst_pkg::status_t res_status_r, res_status_nxt;
  logic             res_pos_zero_r, res_pos_zero_nxt;

  // next state and commands
  always_comb begin
    cmd              = '0;
    cmd.out_status   = res_status_r;
    cmd.pos_zero     = res_pos_zero_r;
    state_nxt        = state_r;
    res_status_nxt   = res_status_r;
    res_pos_zero_nxt = res_pos_zero_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        priority if (st.action == sst_pkg::ACT_CLEAR) begin
          cmd.cnt_clr      = 1'b1;
          res_status_nxt   = sst_pkg::ST_OK;
          res_pos_zero_nxt = 1'b1;
          state_nxt        = S_FINISH;
        end else if (st.action == sst_pkg::ACT_INSERT && st.full) begin
          res_status_nxt   = sst_pkg::ST_FULL;
          res_pos_zero_nxt = 1'b1;
          state_nxt        = S_FINISH;
        end else begin
          state_nxt = S_SCAN_CHK;
        end
      end
      S_SCAN_CHK: begin
        if (st.scan_end) begin
          if (st.action == sst_pkg::ACT_INSERT) begin
            state_nxt = S_INS_START;
          end else begin
            res_status_nxt   = sst_pkg::ST_MISS;
            res_pos_zero_nxt = 1'b1;
            state_nxt        = S_FINISH;
          end
        end else begin
          cmd.rd_idx = 1'b1;
          state_nxt  = S_SCAN_CMP;
        end
      end
      S_SCAN_CMP: begin
        priority if (st.less) begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_SCAN_CHK;
        end else if (st.equal) begin
          unique case (st.action)
            sst_pkg::ACT_SEARCH: begin
              res_status_nxt   = sst_pkg::ST_OK;
              res_pos_zero_nxt = 1'b0;
              state_nxt        = S_FINISH;
            end
            sst_pkg::ACT_INSERT: begin
              res_status_nxt   = sst_pkg::ST_DUP;
              res_pos_zero_nxt = 1'b0;
              state_nxt        = S_FINISH;
            end
            sst_pkg::ACT_DELETE: begin
              cmd.ptr_from_idx = 1'b1;
              state_nxt        = S_DEL_CHK;
            end
            default: begin
              res_status_nxt   = sst_pkg::ST_OK;
              res_pos_zero_nxt = 1'b1;
              state_nxt        = S_FINISH;
            end
          endcase
        end else if (st.action == sst_pkg::ACT_INSERT) begin
          state_nxt = S_INS_START;
        end else begin
          res_status_nxt   = sst_pkg::ST_MISS;
          res_pos_zero_nxt = 1'b1;
          state_nxt        = S_FINISH;
        end
      end
      S_INS_START: begin
        cmd.ptr_from_cnt = 1'b1;
        state_nxt        = S_INS_CHK;
      end
      S_INS_CHK: begin
        if (st.ptr_at_idx) begin
          cmd.wr_value     = 1'b1;
          cmd.cnt_inc      = 1'b1;
          res_status_nxt   = sst_pkg::ST_OK;
          res_pos_zero_nxt = 1'b0;
          state_nxt        = S_FINISH;
        end else begin
          cmd.rd_lo = 1'b1;
          state_nxt = S_INS_WR;
        end
      end
      S_INS_WR: begin
        cmd.wr_shift = 1'b1;
        cmd.ptr_dec  = 1'b1;
        state_nxt    = S_INS_CHK;
      end
      S_DEL_CHK: begin
        if (st.ptr_at_top) begin
          cmd.cnt_dec      = 1'b1;
          res_status_nxt   = sst_pkg::ST_OK;
          res_pos_zero_nxt = 1'b0;
          state_nxt        = S_FINISH;
        end else begin
          cmd.rd_hi = 1'b1;
          state_nxt = S_DEL_WR;
        end
      end
      S_DEL_WR: begin
        cmd.wr_shift = 1'b1;
        cmd.ptr_inc  = 1'b1;
        state_nxt    = S_DEL_CHK;
      end
      S_FINISH: begin
        if (!st.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered result code
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      res_status_r   <= sst_pkg::ST_OK;
      res_pos_zero_r <= 1'b1;
    end else begin
      state_r        <= state_nxt;
      res_status_r   <= res_status_nxt;
      res_pos_zero_r <= res_pos_zero_nxt;
    end
  end

  assign idle = (state_r == S_IDLE);

endmodule

FILE: hw/rtl/sst_dp.sv
// ----------------------------------------------------------------------------
// sst_dp: datapath for the sorted set table
// Entry memory with one write and one registered read port, scan index,
// shift pointer, fill count, comparator and result register.
// ----------------------------------------------------------------------------
module sst_dp #(
  parameter int CAPACITY = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  sst_pkg::in_item_t   in_item,
  input  sst_pkg::dp_cmd_t    cmd,
  output sst_pkg::dp_status_t st,
  input  logic                out_stall,
  output logic                out_valid,
  output sst_pkg::out_item_t  out_item
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
  localparam logic [CW-1:0] ONE_C = CW'(1);

  logic [31:0]        mem [CAPACITY];
  sst_pkg::action_t   act_r;
  logic signed [31:0] val_r;
  logic [CW-1:0]      idx_r;
  logic [CW-1:0]      ptr_r;
  logic [CW-1:0]      cnt_r;
  logic signed [31:0] rdata_r;
  logic               out_valid_r;
  sst_pkg::out_item_t out_item_r;

  logic [CW-1:0]      raddr;
  logic [CW-1:0]      waddr;
  logic [31:0]        wdata;
  logic               rd_en;
  logic               wr_en;
  logic [31:0]        idx_wide;
  logic [31:0]        cnt_wide;

  // captured item, scan index and shift pointer
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      act_r <= in_item.action;
      val_r <= in_item.value;
    end
    if (cmd.take) begin
      idx_r <= '0;
    end else if (cmd.idx_inc) begin
      idx_r <= idx_r + ONE_C;
    end
    priority if (cmd.ptr_from_cnt) begin
      ptr_r <= cnt_r;
    end else if (cmd.ptr_from_idx) begin
      ptr_r <= idx_r;
    end else if (cmd.ptr_dec) begin
      ptr_r <= ptr_r - ONE_C;
    end else if (cmd.ptr_inc) begin
      ptr_r <= ptr_r + ONE_C;
    end
  end

  // fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      priority if (cmd.cnt_clr) begin
        cnt_r <= '0;
      end else if (cmd.cnt_inc) begin
        cnt_r <= cnt_r + ONE_C;
      end else if (cmd.cnt_dec) begin
        cnt_r <= cnt_r - ONE_C;
      end
    end
  end

  // memory address and data selection
  always_comb begin
    priority if (cmd.rd_lo) begin
      raddr = ptr_r - ONE_C;
    end else if (cmd.rd_hi) begin
      raddr = ptr_r + ONE_C;
    end else begin
      raddr = idx_r;
    end
    waddr = cmd.wr_value ? idx_r : ptr_r;
    wdata = cmd.wr_value ? val_r : rdata_r;
    rd_en = cmd.rd_idx | cmd.rd_lo | cmd.rd_hi;
    wr_en = cmd.wr_value | cmd.wr_shift;
  end

  // entry memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[waddr[AW-1:0]] <= wdata;
    end
    if (rd_en) begin
      rdata_r <= mem[raddr[AW-1:0]];
    end
  end

  // result register
  assign idx_wide = 32'(idx_r);
  assign cnt_wide = 32'(cnt_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_item_r.status     <= cmd.out_status;
      out_item_r.position   <= cmd.pos_zero ? 5'd0 : idx_wide[4:0];
      out_item_r.fill_count <= cnt_wide[4:0];
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // status back to the sequencer
  always_comb begin
    st.action     = act_r;
    st.scan_end   = (idx_r >= cnt_r);
    st.less       = (rdata_r < val_r);
    st.equal      = (rdata_r == val_r);
    st.full       = (cnt_r == CAP_C);
    st.ptr_at_idx = (ptr_r == idx_r);
    st.ptr_at_top = ((ptr_r + ONE_C) >= cnt_r);
    st.out_busy   = out_valid_r & out_stall;
  end

endmodule

FILE: hw/rtl/sst_checker.sv
// ----------------------------------------------------------------------------
// sst_checker: port-level checks for the sorted set table
// Watches both channels of the top level and flags results that break the
// table's rules; bound onto every instance of the top level.
// ----------------------------------------------------------------------------
module sst_checker #(
  parameter int CAPACITY = 16
) (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input sst_pkg::out_item_t out_item
);

  // a held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  // one item at a time: busy right after each input transfer
  a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while an item is in progress");

  // full and miss results report position zero
  a_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.status == sst_pkg::ST_FULL ||
                  out_item.status == sst_pkg::ST_MISS) |-> out_item.position == 5'd0)
    else $error("position not zero on a refused or missed action");

  // fill count never passes the capacity
  a_fill_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (CAPACITY > 31) || (32'(out_item.fill_count) <= 32'(CAPACITY)))
    else $error("fill count beyond capacity");

  // reset drops any pending result
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind sorted_set_table sst_checker #(
  .CAPACITY (CAPACITY)
) u_sst_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

FILE: test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the sorted set table
// Drives search, insert, delete and clear transfers with random gaps and
// result back-pressure. A scoreboard keeps its own sorted table, works out
// the status, position and fill count of each transfer and compares them
// with the results in order.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int TABLE_DEPTH    = 16;
  localparam int SLOT_W         = $clog2(TABLE_DEPTH);
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASES         = 10;
  localparam int PHASE_ITEMS    = 125;

  logic               clk;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  sst_pkg::in_item_t  in_item   = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  sst_pkg::out_item_t out_item;

  // set by the stimulus to switch off idling on both sides
  bit no_idle = 1'b0;
  int unsigned stuck_cycles = 0;

  // value pool for the current random phase
  logic signed [31:0] pool [32];
  int unsigned pool_size = 1;

  sorted_set_table #(.CAPACITY(TABLE_DEPTH)) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  // shadow of the sorted table and the queue of results it predicts
  class table_scoreboard;
    logic signed [31:0] slots [TABLE_DEPTH];
    int unsigned        fill;
    sst_pkg::out_item_t awaited_results [$];
    int unsigned        errors;

    function new();
      fill   = 0;
      errors = 0;
    endfunction

    function int unsigned outstanding();
      return awaited_results.size();
    endfunction

    // apply one accepted transfer to the shadow table
    function void apply_request(sst_pkg::in_item_t it);
      sst_pkg::out_item_t r;
      logic signed [31:0] key;
      int unsigned        idx;
      int unsigned        j;
      bit                 hit;
      key      = it.value;
      r        = '0;
      r.status = sst_pkg::ST_OK;
      // first entry not below the key
      idx = 0;
      while (idx < fill && slots[SLOT_W'(idx)] < key) idx++;
      hit = (idx < fill) && (slots[SLOT_W'(idx)] == key);
      case (it.action)
        sst_pkg::ACT_SEARCH: begin
          if (hit) r.position = 5'(idx);
          else r.status = sst_pkg::ST_MISS;
        end
        sst_pkg::ACT_INSERT: begin
          // full takes priority over duplicate
          if (fill >= TABLE_DEPTH) begin
            r.status = sst_pkg::ST_FULL;
          end else if (hit) begin
            r.status   = sst_pkg::ST_DUP;
            r.position = 5'(idx);
          end else begin
            for (j = fill; j > idx; j--) slots[SLOT_W'(j)] = slots[SLOT_W'(j - 1)];
            slots[SLOT_W'(idx)] = key;
            fill++;
            r.position = 5'(idx);
          end
        end
        sst_pkg::ACT_DELETE: begin
          if (!hit) begin
            r.status = sst_pkg::ST_MISS;
          end else begin
            for (j = idx; j + 1 < fill; j++) slots[SLOT_W'(j)] = slots[SLOT_W'(j + 1)];
            fill--;
            r.position = 5'(idx);
          end
        end
        default: fill = 0;
      endcase
      r.fill_count = 5'(fill);
      awaited_results.push_back(r);
    endfunction

    // compare one result transfer with the oldest expectation
    function void check_result(sst_pkg::out_item_t got);
      sst_pkg::out_item_t want;
      if (awaited_results.size() == 0) begin
        $error("result transfer with nothing expected: status %0d position %0d fill %0d",
               got.status, got.position, got.fill_count);
        errors++;
        return;
      end
      want = awaited_results.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
      if (got.position !== want.position) begin
        $error("position: expected %0d, got %0d", want.position, got.position);
        errors++;
      end
      if (got.fill_count !== want.fill_count) begin
        $error("fill_count: expected %0d, got %0d", want.fill_count, got.fill_count);
        errors++;
      end
    endfunction
  endclass

  table_scoreboard sb = new();

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // result side: random back-pressure and checking
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_item);
    out_stall <= !no_idle && ($urandom_range(99) < 16);
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= WATCHDOG_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // one input transfer, with a random gap in front of it
  task automatic send_item(input sst_pkg::action_t act, input logic signed [31:0] val);
    sst_pkg::in_item_t it;
    it.action = act;
    it.value  = val;
    while (!no_idle && $urandom_range(99) < 16) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
    sb.apply_request(it);
  endtask

  // hold the sender until every expected result is back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  // mix of pool values, live entries, extremes and raw random words
  function automatic logic signed [31:0] pick_value();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 15) return $urandom;
    if (roll < 35 && sb.fill > 0) return sb.slots[SLOT_W'($urandom_range(sb.fill - 1))];
    if (roll < 42) begin
      case ($urandom_range(3))
        0: return 32'sh8000_0000;
        1: return 32'sh7fff_ffff;
        2: return 32'sh0000_0000;
        default: return -32'sd1;
      endcase
    end
    return pool[5'($urandom_range(pool_size - 1))];
  endfunction

  // stimulus
  initial begin
    sst_pkg::action_t act;
    int unsigned      roll;
    int unsigned      ins_pct;
    int unsigned      del_pct;
    int               k;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty table misses
    send_item(sst_pkg::ACT_SEARCH, 32'sd5);
    send_item(sst_pkg::ACT_DELETE, 32'sd5);
    // extremes, front and back insertion, duplicate
    send_item(sst_pkg::ACT_INSERT, 32'sh0000_0000);
    send_item(sst_pkg::ACT_INSERT, 32'sh7fff_ffff);
    send_item(sst_pkg::ACT_INSERT, 32'sh8000_0000);
    send_item(sst_pkg::ACT_INSERT, -32'sd1);
    send_item(sst_pkg::ACT_INSERT, 32'sh0000_0000);
    send_item(sst_pkg::ACT_SEARCH, -32'sd1);
    send_item(sst_pkg::ACT_SEARCH, 32'sd1);
    // fill the table up
    for (k = 0; k < 12; k++) send_item(sst_pkg::ACT_INSERT, 32'(k * 37 - 200));
    // full table: present and new values both refused as full
    send_item(sst_pkg::ACT_INSERT, 32'sh0000_0000);
    send_item(sst_pkg::ACT_INSERT, 32'sd7);
    // removal at bottom, top and middle, then clear
    send_item(sst_pkg::ACT_DELETE, 32'sh8000_0000);
    send_item(sst_pkg::ACT_DELETE, 32'sh7fff_ffff);
    send_item(sst_pkg::ACT_DELETE, 32'sh0000_0000);
    send_item(sst_pkg::ACT_CLEAR, 32'sh0000_0000);
    drain_results();

    // random phases, each with its own pool and action mix
    for (int phase = 0; phase < PHASES; phase++) begin
      pool_size = $urandom_range(12, 32);
      for (k = 0; k < 32; k++) begin
        if (phase % 2 == 0) pool[5'(k)] = $urandom;
        else pool[5'(k)] = $signed($urandom_range(40)) - 32'sd20;
      end
      ins_pct = $urandom_range(30, 55);
      del_pct = $urandom_range(20, 35);
      no_idle = (phase == 4);
      for (k = 0; k < PHASE_ITEMS; k++) begin
        roll = $urandom_range(99);
        if (roll < 2) act = sst_pkg::ACT_CLEAR;
        else if (roll < 2 + ins_pct) act = sst_pkg::ACT_INSERT;
        else if (roll < 2 + ins_pct + del_pct) act = sst_pkg::ACT_DELETE;
        else act = sst_pkg::ACT_SEARCH;
        send_item(act, pick_value());
      end
      if (phase % 3 == 2) drain_results();
    end
    no_idle = 1'b0;

    // wait for the tail, then allow for a last stray result
    drain_results();
    repeat (60) @(posedge clk);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
